// ===== src/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and constants for the bounded deque engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bde_pkg;

  // Configuration port geometry
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register index, taken from paddr[2]
  localparam logic REG_CAPACITY_LIMIT = 1'b0;

  localparam logic [3:0]  LIMIT_RESET = 4'd5;
  localparam logic [63:0] EMPTY_MARK  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_CLEAR      = 3'd4,
    MODE_QUERY      = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EXEC  = 2'd1,
    ST_FETCH = 2'd2,
    ST_REPLY = 2'd3
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the input item
    logic exec;   // apply operation, write store, read popped entry
    logic fetch;  // capture popped entry, read front and back entries
  } cmd_t;

endpackage

// ===== src/bde_cfg.sv =====
// ----------------------------------------------------------------------------
// bde_cfg
// APB register file holding the fill limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bde_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bde_pkg::ADDR_W-1:0] paddr,
  input  logic [bde_pkg::DATA_W-1:0] pwdata,
  output logic [bde_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [3:0]                 limit_o
);

  logic [3:0] limit_q, limit_d;
  logic       hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == bde_pkg::REG_CAPACITY_LIMIT);

  always_comb begin
    limit_d = limit_q;
    if (psel && penable && pwrite && hit) begin
      limit_d = pwdata[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= bde_pkg::LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign prdata  = hit ? {{(bde_pkg::DATA_W-4){1'b0}}, limit_q} : '0;
  assign limit_o = limit_q;

endmodule

// ===== src/bde_ctrl.sv =====
// ----------------------------------------------------------------------------
// bde_ctrl
// Sequencer: accept, execute, fetch, reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bde_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output bde_pkg::cmd_t cmd_o
);

  bde_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bde_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    busy      = 1'b0;
    done_o    = 1'b0;
    case (state_q)
      bde_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = bde_pkg::ST_EXEC;
        end
      end
      bde_pkg::ST_EXEC: begin
        busy       = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = bde_pkg::ST_FETCH;
      end
      bde_pkg::ST_FETCH: begin
        busy        = 1'b1;
        cmd_o.fetch = 1'b1;
        state_d     = bde_pkg::ST_REPLY;
      end
      bde_pkg::ST_REPLY: begin
        // result shown this cycle; next item may be taken alongside
        done_o = 1'b1;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = bde_pkg::ST_EXEC;
        end else begin
          state_d = bde_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bde_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/bde_dp.sv =====
// ----------------------------------------------------------------------------
// bde_dp
// Circular store, head/count pointers and result formatting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bde_dp #(
  parameter int STORE_DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bde_pkg::cmd_t       cmd_i,
  input  logic [2:0]          mode_i,
  input  logic signed [63:0]  push_value_i,
  input  logic [3:0]          limit_i,
  output logic [1:0]          status_o,
  output logic signed [63:0]  popped_value_o,
  output logic signed [63:0]  front_value_o,
  output logic signed [63:0]  back_value_o,
  output logic [3:0]          entry_count_o,
  output logic                is_empty_o,
  output logic                is_full_o
);

  localparam int IdxW = $clog2(STORE_DEPTH);
  localparam int SumW = ((IdxW > 4) ? IdxW : 4) + 1;
  localparam logic [3:0]      DepthCap = (STORE_DEPTH > 15) ? 4'd15 : 4'(STORE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(STORE_DEPTH - 1);
  localparam logic [SumW-1:0] DepthW   = SumW'(STORE_DEPTH);

  // offset is below the depth wherever the slot is used, so one subtract wraps it
  function automatic logic [IdxW-1:0] slot_of(input logic [IdxW-1:0] base,
                                              input logic [3:0]      ofs);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(ofs);
    if (sum >= DepthW) begin
      sum = sum - DepthW;
    end
    return sum[IdxW-1:0];
  endfunction

  logic [63:0] mem [STORE_DEPTH];

  bde_pkg::mode_e   mode_q;
  logic [63:0]      value_q;
  logic [IdxW-1:0]  head_q, head_d;
  logic [3:0]       count_q, count_d;
  bde_pkg::status_e status_q, status_d;
  logic             pop_ok_q, pop_ok_d;
  logic [63:0]      popped_q;
  logic [63:0]      rd_a_q, rd_b_q;

  logic [3:0]       eff_limit;
  logic             push_ok;
  logic             we;
  logic [IdxW-1:0]  waddr, pop_addr, rd_a_addr, back_addr;

  assign eff_limit = (limit_i > DepthCap) ? DepthCap : limit_i;
  assign push_ok   = (count_q < eff_limit);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    we       = 1'b0;
    waddr    = slot_of(head_q, count_q);
    pop_addr = head_q;
    if (cmd_i.exec) begin
      status_d = bde_pkg::STATUS_OK;
      pop_ok_d = 1'b0;
      case (mode_q)
        bde_pkg::MODE_PUSH_FRONT: begin
          if (push_ok) begin
            head_d  = (head_q == '0) ? LastIdx : head_q - IdxW'(1);
            waddr   = head_d;
            we      = 1'b1;
            count_d = count_q + 4'd1;
          end else begin
            status_d = bde_pkg::STATUS_OVERFLOW;
          end
        end
        bde_pkg::MODE_PUSH_BACK: begin
          if (push_ok) begin
            we      = 1'b1;
            count_d = count_q + 4'd1;
          end else begin
            status_d = bde_pkg::STATUS_OVERFLOW;
          end
        end
        bde_pkg::MODE_POP_FRONT: begin
          if (count_q != 4'd0) begin
            pop_ok_d = 1'b1;
            head_d   = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
            count_d  = count_q - 4'd1;
          end else begin
            status_d = bde_pkg::STATUS_UNDERFLOW;
          end
        end
        bde_pkg::MODE_POP_BACK: begin
          pop_addr = slot_of(head_q, count_q - 4'd1);
          if (count_q != 4'd0) begin
            pop_ok_d = 1'b1;
            count_d  = count_q - 4'd1;
          end else begin
            status_d = bde_pkg::STATUS_UNDERFLOW;
          end
        end
        bde_pkg::MODE_CLEAR: begin
          head_d  = '0;
          count_d = 4'd0;
        end
        default: begin
          // query and unused codes change nothing
        end
      endcase
    end
  end

  assign rd_a_addr = cmd_i.fetch ? head_q : pop_addr;
  assign back_addr = slot_of(head_q, count_q - 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= 4'd0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= bde_pkg::mode_e'(mode_i);
      value_q <= push_value_i;
    end
    status_q <= status_d;
    pop_ok_q <= pop_ok_d;
    if (cmd_i.fetch) begin
      popped_q <= pop_ok_q ? rd_a_q : 64'd0;
    end
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= value_q;
    end
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[back_addr];
  end

  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign front_value_o  = (count_q == 4'd0) ? bde_pkg::EMPTY_MARK : rd_a_q;
  assign back_value_o   = (count_q == 4'd0) ? bde_pkg::EMPTY_MARK : rd_b_q;
  assign entry_count_o  = count_q;
  assign is_empty_o     = (count_q == 4'd0);
  assign is_full_o      = (count_q == eff_limit);

endmodule

// ===== src/bounded_deque_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed 64-bit values in a circular store.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low. Its
// result follows the execute and fetch states: done_o is high for exactly one
// cycle and the result ports are valid only in that cycle. The receiver
// cannot stall, so sample the result whenever done_o is high. busy stays
// high in the execute and fetch states after acceptance; a new item may be
// started in the same cycle a result is shown. The fetch state is needed as
// the store's read ports are registered: the popped entry is read in the
// execute cycle and the new front and back entries in the fetch cycle.
// The fill limit (capacity_limit, reset 5) lives at byte address 0 of the
// APB port; write it only while no item is in flight. A limit above the store
// depth is clamped to the depth. Store entries hold no reset value; only
// written entries reach the outputs. Mode codes 6 and 7 behave as a query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_deque_engine #(
  parameter int STORE_DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 mode_i,
  input  logic signed [63:0]         push_value_i,
  // result channel
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic signed [63:0]         popped_value_o,
  output logic signed [63:0]         front_value_o,
  output logic signed [63:0]         back_value_o,
  output logic [3:0]                 entry_count_o,
  output logic                       is_empty_o,
  output logic                       is_full_o,
  // APB configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bde_pkg::ADDR_W-1:0] paddr,
  input  logic [bde_pkg::DATA_W-1:0] pwdata,
  output logic [bde_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  bde_pkg::cmd_t cmd;
  logic [3:0]    limit;

  // fill limit register
  bde_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  // sequencer: idle -> execute -> fetch -> reply
  bde_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // store, pointers and result fields; outputs are valid while done_o is high
  bde_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .mode_i         (mode_i),
    .push_value_i   (push_value_i),
    .limit_i        (limit),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

endmodule

// ===== src/bde_checker.sv =====
// ----------------------------------------------------------------------------
// bde_checker
// Port-level checks for the bounded deque engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bde_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic signed [63:0] popped_value_o,
  input logic signed [63:0] front_value_o,
  input logic signed [63:0] back_value_o,
  input logic [3:0]         entry_count_o,
  input logic               is_empty_o
);

  // an accepted item yields its result after the execute and fetch states
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result missing three cycles after accept");

  // engine is busy right after accepting an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("not busy after accept");

  // empty flag agrees with count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (is_empty_o == (entry_count_o == 4'd0)))
    else $error("empty flag disagrees with count");

  // empty queue reports the empty mark at both ends
  a_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (front_value_o == -64'sd1 && back_value_o == -64'sd1))
    else $error("empty queue shows stale entries");

  // a refused operation pops nothing
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bde_pkg::STATUS_OK) |-> (popped_value_o == 64'sd0))
    else $error("refused operation reports a popped value");

endmodule

bind bounded_deque_engine bde_checker u_bde_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .status_o       (status_o),
  .popped_value_o (popped_value_o),
  .front_value_o  (front_value_o),
  .back_value_o   (back_value_o),
  .entry_count_o  (entry_count_o),
  .is_empty_o     (is_empty_o)
);
